>>> design/udm64_pkg.sv
// Shared widths and pipeline types for the unsigned 64-bit divider.
package udm64_pkg;

  // Operand width the divider works on (2..64); port fields stay 64 bits.
  localparam int unsigned WIDTH   = 64;
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned TDATA_W = 2 * FIELD_W;

  // One item in flight: remainder/dividend-quotient shift word plus divisor.
  typedef struct packed {
    logic [2*WIDTH-1:0] rq;   // high half: partial remainder, low half: dividend/quotient
    logic [WIDTH-1:0]   dvsr;
    logic               dz;   // divisor was zero
  } udm64_stage_t;

  // Finished result.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] quo;
  } udm64_res_t;

endpackage

>>> design/unsigned_divmod_64_top.sv
// Top level: 64-stage pipelined restoring divider returning quotient and remainder.
// Each item takes one restoring step per pipeline stage, then passes through the output register.
// Throughput: one item per cycle while the skid slot is free; each stage holds one 64-bit subtract-and-select.
// Backpressure freezes the whole stage chain only once the output skid slot is full.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module unsigned_divmod_64_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [udm64_pkg::TDATA_W-1:0]     in_tdata,   // [63:0] dividend, [127:64] divisor
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [udm64_pkg::TDATA_W-1:0]     out_tdata   // [63:0] quotient, [127:64] remainder
);

  localparam int unsigned W  = udm64_pkg::WIDTH;
  localparam int unsigned FW = udm64_pkg::FIELD_W;

  logic                    stage_en;
  udm64_pkg::udm64_stage_t entry;
  logic [W-1:0]            st_valid;
  udm64_pkg::udm64_stage_t st_data [W];
  udm64_pkg::udm64_res_t   res_in;
  udm64_pkg::udm64_res_t   res_out;
  logic                    skid_ready;
  logic [FW-1:0]           quo_ext;
  logic [FW-1:0]           rem_ext;

  // The whole chain advances together whenever the skid slot is free.
  assign stage_en  = skid_ready;
  assign in_tready = stage_en;

  // Entry word: zero remainder, dividend in the low half; only low WIDTH bits used.
  always_comb begin
    entry.rq   = {{W{1'b0}}, in_tdata[W-1:0]};
    entry.dvsr = in_tdata[FW+W-1:FW];
    entry.dz   = ~|in_tdata[FW+W-1:FW];
  end

  // One stage per quotient bit, most significant first.
  for (genvar i = 0; i < W; i++) begin : g_stage
    if (i == 0) begin : g_first
      udm64_stage u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (stage_en),
        .valid_in (in_tvalid),
        .data_in  (entry),
        .valid_r  (st_valid[i]),
        .data_r   (st_data[i])
      );
    end else begin : g_rest
      udm64_stage u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (stage_en),
        .valid_in (st_valid[i-1]),
        .data_in  (st_data[i-1]),
        .valid_r  (st_valid[i]),
        .data_r   (st_data[i])
      );
    end
  end

  // Zero divisor forces both results to zero.
  always_comb begin
    res_in.quo = st_data[W-1].dz ? '0 : st_data[W-1].rq[W-1:0];
    res_in.rem = st_data[W-1].dz ? '0 : st_data[W-1].rq[2*W-1:W];
  end

  udm64_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (st_valid[W-1]),
    .s_ready (skid_ready),
    .s_data  (res_in),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (res_out)
  );

  // Bits above WIDTH read as zero.
  always_comb begin
    quo_ext        = '0;
    rem_ext        = '0;
    quo_ext[W-1:0] = res_out.quo;
    rem_ext[W-1:0] = res_out.rem;
  end

  assign out_tdata = {rem_ext, quo_ext};

endmodule

>>> design/udm64_stage.sv
// One restoring division step with its pipeline register.
module udm64_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_in,
  input  udm64_pkg::udm64_stage_t data_in,
  output logic                    valid_r,
  output udm64_pkg::udm64_stage_t data_r
);

  localparam int unsigned W = udm64_pkg::WIDTH;

  logic                    carry;
  logic [W-1:0]            rem_sh;
  logic [W:0]              trial;
  logic                    take;
  udm64_pkg::udm64_stage_t data_nxt;

  // Shift remainder left by one, bring in the next dividend bit, try subtract.
  always_comb begin
    carry    = data_in.rq[2*W-1];
    rem_sh   = data_in.rq[2*W-2:W-1];
    trial    = {1'b0, rem_sh} - {1'b0, data_in.dvsr};
    take     = carry | ~trial[W];
    data_nxt = data_in;
    data_nxt.rq[2*W-1:W] = take ? trial[W-1:0] : rem_sh;
    data_nxt.rq[W-1:0]   = {data_in.rq[W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/udm64_skid.sv
// Output register with skid slot; ready toward the pipeline is registered.
module udm64_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  udm64_pkg::udm64_res_t s_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output udm64_pkg::udm64_res_t m_data
);

  logic                  main_valid_r;
  udm64_pkg::udm64_res_t main_data_r;
  logic                  skid_valid_r;
  udm64_pkg::udm64_res_t skid_data_r;
  logic                  load_main;

  assign s_ready   = ~skid_valid_r;
  assign m_valid   = main_valid_r;
  assign m_data    = main_data_r;
  assign load_main = m_ready | ~main_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_main) begin
      main_valid_r <= skid_valid_r | s_valid;
      skid_valid_r <= 1'b0;
    end else if (s_valid && s_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      main_data_r <= skid_valid_r ? skid_data_r : s_data;
    end else if (s_valid && s_ready) begin
      skid_data_r <= s_data;
    end
  end

  // skid slot only fills behind a held item
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid holds an item while output register is empty");

  // an item arriving at a stalled output must be parked, not dropped
  a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid && s_ready && main_valid_r && !m_ready) |=> skid_valid_r)
    else $error("item lost at stalled output");

  // a parked item moves to the output as soon as the output frees up
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && m_ready) |=> (main_valid_r && !skid_valid_r))
    else $error("skid item not promoted");

endmodule
